@@ src/bbc_pkg.sv @@
// shared types, constants and codes of the bracket balance checker
package bbc_pkg;

    // sizing
    localparam int STACK_DEPTH = 128;
    localparam int COUNT_BITS  = 16;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // stream widths
    localparam int CHAR_W     = 8;
    localparam int MCOUNT_W   = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // text bytes
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_RND_O  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RND_C  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SQR_O  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SQR_C  = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_CRL_O  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CRL_C  = 8'h7D;

    // input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // bracket codes kept on the stack
    typedef enum logic [2:0] {
        BR_NONE   = 3'd0,
        BR_ROUND  = 3'd1,
        BR_SQUARE = 3'd2,
        BR_CURLY  = 3'd3,
        BR_ANGLE  = 3'd4,
        BR_DANGLE = 3'd5
    } t_bracket;

    // lone angle held back for pairing
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_LT   = 2'd1,
        PEND_GT   = 2'd2
    } t_pend;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_EOL  = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        t_bracket code;
    } t_op;

    // one queue entry: optional flush op, then the item's own op
    typedef struct packed {
        t_op op_a;
        t_op op_b;
    } t_entry;

    // verdict in the lowest bit
    typedef struct packed {
        logic                overflow;
        logic [MCOUNT_W-1:0] match_count;
        logic                verdict;
    } t_result;

endpackage

@@ src/bbc_front.sv @@
// front end: pairs angle characters and turns each beat into stack operations
module bbc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_command,
    input  logic [bbc_pkg::CHAR_W-1:0] i_character,
    output logic                       o_push,
    output bbc_pkg::t_entry            o_entry
);
    import bbc_pkg::*;

    t_pend  r_pend;
    t_pend  n_pend;
    t_op    w_flush;
    t_op    w_own;
    t_entry w_entry;
    logic   w_pair;

    // second angle of a pair, nothing to flush
    assign w_pair = (i_command == CMD_CHAR)
                    && (((r_pend == PEND_LT) && (i_character == CH_LT))
                        || ((r_pend == PEND_GT) && (i_character == CH_GT)));

    always_comb begin
        w_flush = '{kind: OP_NONE, code: BR_NONE};
        if (!w_pair) begin
            unique case (r_pend)
                PEND_LT: w_flush = '{kind: OP_PUSH, code: BR_ANGLE};
                PEND_GT: w_flush = '{kind: OP_POP,  code: BR_ANGLE};
                default: w_flush = '{kind: OP_NONE, code: BR_NONE};
            endcase
        end
    end

    always_comb begin
        n_pend = PEND_NONE;
        w_own  = '{kind: OP_NONE, code: BR_NONE};
        if (i_command == CMD_EOL) begin
            w_own = '{kind: OP_EOL, code: BR_NONE};
        end else if (r_pend == PEND_LT && i_character == CH_LT) begin
            w_own = '{kind: OP_PUSH, code: BR_DANGLE};
        end else if (r_pend == PEND_GT && i_character == CH_GT) begin
            w_own = '{kind: OP_POP, code: BR_DANGLE};
        end else begin
            unique case (i_character)
                CH_LT:    n_pend = PEND_LT;
                CH_GT:    n_pend = PEND_GT;
                CH_RND_O: w_own  = '{kind: OP_PUSH, code: BR_ROUND};
                CH_SQR_O: w_own  = '{kind: OP_PUSH, code: BR_SQUARE};
                CH_CRL_O: w_own  = '{kind: OP_PUSH, code: BR_CURLY};
                CH_RND_C: w_own  = '{kind: OP_POP,  code: BR_ROUND};
                CH_SQR_C: w_own  = '{kind: OP_POP,  code: BR_SQUARE};
                CH_CRL_C: w_own  = '{kind: OP_POP,  code: BR_CURLY};
                default:  w_own  = '{kind: OP_NONE, code: BR_NONE};
            endcase
        end
    end

    // a single op always sits in op_b
    always_comb begin
        if (w_own.kind == OP_NONE) begin
            w_entry = '{op_a: '{kind: OP_NONE, code: BR_NONE}, op_b: w_flush};
        end else begin
            w_entry = '{op_a: w_flush, op_b: w_own};
        end
    end

    assign o_entry = w_entry;
    assign o_push  = i_accept && (w_entry.op_b.kind != OP_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
        end else if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

@@ src/bbc_queue.sv @@
// short queue of stack operations between front and back end
module bbc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbc_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output bbc_pkg::t_entry o_entry
);
    import bbc_pkg::*;

    t_entry              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/bbc_back.sv @@
// back end: bracket stack, failure and count tracking, verdict register
module bbc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bbc_pkg::t_entry   i_entry,
    output logic              o_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output bbc_pkg::t_result  o_result
);
    import bbc_pkg::*;

    logic [2:0]            r_mem [STACK_DEPTH];
    logic [LVL_W-1:0]      r_level;
    logic [LVL_W-1:0]      n_level;
    t_bracket              r_top;
    logic [2:0]            r_second;
    logic                  r_failed;
    logic                  r_ovf;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_phase;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  w_do_a;
    t_op                   w_op;
    logic                  w_out_free;
    logic                  w_step;
    logic                  w_push_ok;
    logic                  w_pop_go;
    logic                  w_eol;
    logic [LVL_W-1:0]      w_rd_lvl;

    assign w_do_a     = i_valid && !r_phase && (i_entry.op_a.kind != OP_NONE);
    assign w_op       = w_do_a ? i_entry.op_a : i_entry.op_b;
    assign w_out_free = !r_out_valid || i_res_ready;
    assign w_step     = i_valid && !((w_op.kind == OP_EOL) && !w_out_free);
    assign o_pop      = w_step && !w_do_a;

    assign w_eol     = w_step && (w_op.kind == OP_EOL);
    assign w_push_ok = w_step && (w_op.kind == OP_PUSH) && !r_failed
                       && (r_level != LVL_W'(STACK_DEPTH));
    assign w_pop_go  = w_step && (w_op.kind == OP_POP) && !r_failed;

    always_comb begin
        n_level = r_level;
        if (w_eol) begin
            n_level = '0;
        end else if (w_push_ok) begin
            n_level = r_level + 1'b1;
        end else if (w_pop_go && (r_level != '0)) begin
            n_level = r_level - 1'b1;
        end
    end

    // second entry from the top is prefetched for the next pop
    assign w_rd_lvl = n_level - LVL_W'(2);

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[IDX_W'(r_level)] <= w_op.code;
        end
        r_second <= r_mem[IDX_W'(w_rd_lvl)];
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_top <= w_op.code;
        end else if (w_pop_go && (r_level != '0)) begin
            r_top <= t_bracket'(r_second);
        end
        if (w_eol) begin
            r_out.verdict     <= r_failed || (r_level != '0);
            r_out.match_count <= MCOUNT_W'(r_count);
            r_out.overflow    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_level <= n_level;
            if (w_step) begin
                r_phase <= w_do_a;
            end
            if (w_eol) begin
                r_failed <= 1'b0;
                r_ovf    <= 1'b0;
                r_count  <= '0;
            end else begin
                if (w_step && (w_op.kind == OP_PUSH) && !r_failed
                    && (r_level == LVL_W'(STACK_DEPTH))) begin
                    r_ovf <= 1'b1;
                end
                if (w_pop_go) begin
                    if ((r_level == '0) || (r_top != w_op.code)) begin
                        r_failed <= 1'b1;
                    end else if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            if (w_eol) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

@@ src/bracket_balance_checker_unit.sv @@
// top level of the bracket balance checker
//
// usage
//   input stream: one text byte per beat on s_axis_tdata, s_axis_tuser is the
//   command (0 = character, 1 = end of line). brackets () [] {} <> and the
//   two-character << >> are checked; a lone '<' or '>' is held back until the
//   next beat so that two in a row pair greedily. other bytes are skipped
//   output stream: one beat per end of line with verdict (0 = balanced),
//   matched pair count (saturating) and a flag that an opener was dropped
//   because the stack was full. the line state is cleared after it
// throughput: one input beat per cycle while the queue has space. the front
//   end turns a beat into at most two stack operations; the stack unit runs
//   one operation a cycle unless an end of line waits on a full output register;
//   a four-entry operation queue absorbs the extra operation of a flush
// path: an end-of-line beat is registered in the operation queue, then in
//   the output register; a flushed held angle runs as a stack operation first
// reset: i_rst_n is synchronous, active low; it empties the queue, the
//   stack level, the held angle and the output register
// stall: a waiting verdict holds in its output register; input is still
//   taken until the queue fills, then s_axis_tready drops
module bracket_balance_checker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bbc_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [7:0] character
    input  logic                          s_axis_tuser,  // [0] command
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] verdict, [16:1] match_count, [17] overflow, [23:18] zero
    output logic [bbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bbc_pkg::*;

    logic    w_accept;
    logic    w_push;
    t_entry  w_entry;
    logic    w_full;
    logic    w_q_valid;
    t_entry  w_q_entry;
    logic    w_q_pop;
    t_result w_result;

    // front only waits on queue space
    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && !w_full;

    bbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_command   (s_axis_tuser),
        .i_character (s_axis_tdata[CHAR_W-1:0]),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    bbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_entry     (w_q_entry),
        .o_pop       (w_q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_result    (w_result)
    );

    // zero fill up to whole bytes
    assign m_axis_tdata = OUT_DATA_W'(w_result);

endmodule

@@ src/bbc_checker.sv @@
// port-level checks of the bracket balance checker, bound to the top level
module bbc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [bbc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bbc_pkg::*;

    // a waiting verdict stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("verdict beat dropped before it was taken");

    // an offered text beat stays unchanged until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("text beat changed before it was taken");

    // reset leaves no verdict pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid right after reset");

    // reset leaves the operation queue empty
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // padding bits of a verdict beat are zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:18] == '0))
        else $error("verdict beat padding not zero");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (.*);
